// ===== rtl/core/radial_height_brush_unit_defines.svh =====
// Shared assertion macros for the brush unit checker.
`ifndef RADIAL_HEIGHT_BRUSH_UNIT_DEFINES_SVH
`define RADIAL_HEIGHT_BRUSH_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define RHB_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion, checked in every cycle.
`define RHB_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/rhb_pkg.sv =====
package rhb_pkg;

    localparam int COORD_W    = 10;
    localparam int HEIGHT_W   = 24;
    localparam int RAD_W      = 19;
    localparam int MAXR_W     = RAD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SIDE_W     = HEIGHT_W + 2;

    localparam int DEF_GRID_SIZE = 1024;
    localparam int DEF_FRAC_BITS = 8;

    localparam logic signed [HEIGHT_W-1:0] HMAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
    localparam logic signed [HEIGHT_W-1:0] HMIN = {1'b1, {(HEIGHT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_RAISE_RADIUS  = 3'd2,
        CFG_FEATHER_WIDTH = 3'd3,
        CFG_LIFT_AMOUNT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0]         cell_col;
        logic [COORD_W-1:0]         cell_row;
        logic signed [HEIGHT_W-1:0] cell_height;
    } t_cell;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] new_height;
        logic                       touched;
        logic                       clipped;
    } t_result;

    // Width of the squared distance in fixed point.
    function automatic int rhb_d2_w(input int frac);
        return 2 * COORD_W + 1 + 2 * frac;
    endfunction

    function automatic int rhb_root_w(input int frac);
        return (rhb_d2_w(frac) + 1) / 2;
    endfunction

    // Four front stages, square root, two ring stages, divider, output register.
    function automatic int rhb_latency(input int frac);
        return 4 + rhb_root_w(frac) + 2 + HEIGHT_W + 1;
    endfunction

endpackage

// ===== rtl/core/radial_height_brush_unit.sv =====
// Channel   Direction  Handshake                  Payload
// cell      in         start (busy always low)    i_cell   : t_cell
// result    out        o_done, one-cycle strobe   o_res    : t_result
// config    in         i_cfg_we, i_cfg_idx        i_cfg_data
//
// One item per cycle; the pipeline runs through four front stages, one stage per
// square-root bit, two ring stages, one stage per quotient bit of the divider,
// and the output register.
// Reset is synchronous, active low; it clears the config registers and every
// valid bit, so items in flight are dropped. The receiver cannot stall, so
// nothing ever holds the pipeline and busy stays low.
module radial_height_brush_unit import rhb_pkg::*; #(
    parameter int GRID_SIZE = DEF_GRID_SIZE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_cell                 i_cell,
    output logic                  busy,
    output logic                  o_done,
    output t_result               o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int D2_W    = rhb_d2_w(FRAC_BITS);
    localparam int ROOT_W  = rhb_root_w(FRAC_BITS);
    localparam int RR_SQ_W = 2 * RAD_W;
    localparam int MR_SQ_W = 2 * MAXR_W;
    localparam int CMP_W   = (D2_W > MR_SQ_W) ? D2_W : MR_SQ_W;
    localparam int DIF_W   = (ROOT_W > MAXR_W) ? ROOT_W : MAXR_W;
    localparam int PROD_W  = RAD_W + HEIGHT_W;

    // Configuration registers.
    logic [COORD_W-1:0]         r_cx;
    logic [COORD_W-1:0]         r_cy;
    logic [RAD_W-1:0]           r_rr;
    logic [RAD_W-1:0]           r_fw;
    logic signed [HEIGHT_W-1:0] r_lift;

    // Radius squares, refreshed every cycle from the config registers. The user
    // must change config only while idle; the block does not enforce it. The compare
    // sits three stages in, so the lag of the registered squares never shows.
    logic [RR_SQ_W-1:0] r_rr_sq;
    logic [MR_SQ_W-1:0] r_mr_sq;
    logic [MAXR_W-1:0]  maxr;
    logic [HEIGHT_W-1:0] mag;

    assign maxr = MAXR_W'(r_rr) + MAXR_W'(r_fw);
    // Magnitude of the lift; the most negative value maps to 2^23 unsigned.
    assign mag  = r_lift[HEIGHT_W-1] ? (~r_lift + 1'b1) : r_lift;
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_rr   <= '0;
            r_fw   <= '0;
            r_lift <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X:      r_cx   <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_Y:      r_cy   <= i_cfg_data[COORD_W-1:0];
                CFG_RAISE_RADIUS:  r_rr   <= i_cfg_data[RAD_W-1:0];
                CFG_FEATHER_WIDTH: r_fw   <= i_cfg_data[RAD_W-1:0];
                CFG_LIFT_AMOUNT:   r_lift <= $signed(i_cfg_data[HEIGHT_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rr_sq <= r_rr * r_rr;
        r_mr_sq <= maxr * maxr;
    end

    // Stage 1: grid check and absolute offsets from the center.
    logic                       r_s1_v, r_s1_on;
    logic [COORD_W-1:0]         r_s1_dx, r_s1_dy;
    logic signed [HEIGHT_W-1:0] r_s1_h;
    // Stage 2: squared offsets.
    logic                       r_s2_v, r_s2_on;
    logic [2*COORD_W-1:0]       r_s2_dxsq, r_s2_dysq;
    logic signed [HEIGHT_W-1:0] r_s2_h;
    // Stage 3: squared distance in whole cells.
    logic                       r_s3_v, r_s3_on;
    logic [2*COORD_W:0]         r_s3_d2;
    logic signed [HEIGHT_W-1:0] r_s3_h;
    // Stage 4: reach tests and fixed-point squared distance.
    logic                       r_s4_v, r_s4_touch, r_s4_full;
    logic [D2_W-1:0]            r_s4_d2;
    logic signed [HEIGHT_W-1:0] r_s4_h;

    logic [D2_W-1:0] s3_d2fx;
    assign s3_d2fx = D2_W'(r_s3_d2) << (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= start && !busy;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_on <= (32'(i_cell.cell_col) < 32'(GRID_SIZE))
                && (32'(i_cell.cell_row) < 32'(GRID_SIZE));
        r_s1_dx <= (i_cell.cell_col >= r_cx) ? (i_cell.cell_col - r_cx)
                                             : (r_cx - i_cell.cell_col);
        r_s1_dy <= (i_cell.cell_row >= r_cy) ? (i_cell.cell_row - r_cy)
                                             : (r_cy - i_cell.cell_row);
        r_s1_h  <= i_cell.cell_height;

        r_s2_on   <= r_s1_on;
        r_s2_dxsq <= r_s1_dx * r_s1_dx;
        r_s2_dysq <= r_s1_dy * r_s1_dy;
        r_s2_h    <= r_s1_h;

        r_s3_on <= r_s2_on;
        r_s3_d2 <= (2*COORD_W+1)'(r_s2_dxsq) + (2*COORD_W+1)'(r_s2_dysq);
        r_s3_h  <= r_s2_h;

        // Off-grid cells count as out of reach.
        r_s4_touch <= r_s3_on && (CMP_W'(s3_d2fx) <= CMP_W'(r_mr_sq));
        r_s4_full  <= (CMP_W'(s3_d2fx) <= CMP_W'(r_rr_sq));
        r_s4_d2    <= s3_d2fx;
        r_s4_h     <= r_s3_h;
    end

    // Square root of the fixed-point squared distance, height and flags riding along.
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;

    rhb_sqrt #(
        .IN_W   (D2_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_v),
        .i_rad   (r_s4_d2),
        .i_side  ({r_s4_h, r_s4_touch, r_s4_full}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage 5: ring depth n = min(maxr - d, feather_width). Only meaningful in
    // the ring, where d <= maxr holds.
    logic                 r_s5_v;
    logic [SIDE_W-1:0]    r_s5_side;
    logic [RAD_W-1:0]     r_s5_n;
    // Stage 6: lift magnitude times depth.
    logic                 r_s6_v;
    logic [SIDE_W-1:0]    r_s6_side;
    logic [PROD_W-1:0]    r_s6_prod;

    logic [DIF_W-1:0] s5_diff;
    assign s5_diff = DIF_W'(maxr) - DIF_W'(sq_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            r_s5_v <= sq_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_side <= sq_side;
        r_s5_n    <= (s5_diff < DIF_W'(r_fw)) ? RAD_W'(s5_diff) : r_fw;
        r_s6_side <= r_s5_side;
        r_s6_prod <= r_s5_n * mag;
    end

    // Divide by the feather width, one quotient bit per stage. The quotient
    // never exceeds the lift magnitude, so HEIGHT_W bits hold it.
    logic                dv_v;
    logic [HEIGHT_W-1:0] dv_q;
    logic [SIDE_W-1:0]   dv_side;

    rhb_div #(
        .DEN_W  (RAD_W),
        .Q_W    (HEIGHT_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s6_v),
        .i_num   (r_s6_prod),
        .i_den   (r_fw),
        .i_side  (r_s6_side),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_side  (dv_side)
    );

    // Final stage: pick the added amount, add, saturate.
    logic signed [HEIGHT_W-1:0] fin_h;
    logic                       fin_touch, fin_full;
    logic signed [HEIGHT_W:0]   fin_add;
    logic signed [HEIGHT_W:0]   fin_sum;
    t_result                    n_res;

    assign {fin_h, fin_touch, fin_full} = dv_side;

    always_comb begin
        if (fin_full) begin
            fin_add = {r_lift[HEIGHT_W-1], r_lift};
        end else if (r_lift[HEIGHT_W-1]) begin
            fin_add = -$signed({1'b0, dv_q});
        end else begin
            fin_add = $signed({1'b0, dv_q});
        end
        fin_sum = {fin_h[HEIGHT_W-1], fin_h} + fin_add;

        n_res.touched    = fin_touch;
        n_res.clipped    = 1'b0;
        n_res.new_height = fin_h;
        if (fin_touch) begin
            if (fin_sum[HEIGHT_W] != fin_sum[HEIGHT_W-1]) begin
                // Clamp to whichever bound the sum ran past.
                n_res.new_height = fin_sum[HEIGHT_W] ? HMIN : HMAX;
                n_res.clipped    = 1'b1;
            end else begin
                n_res.new_height = fin_sum[HEIGHT_W-1:0];
            end
        end
    end

    logic    r_done;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/core/rhb_sqrt.sv =====
module rhb_sqrt import rhb_pkg::*; #(
    parameter int IN_W   = 37,
    parameter int SIDE_W = 26
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [IN_W-1:0]           i_rad,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [(IN_W+1)/2-1:0]     o_root,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int STEPS  = (IN_W + 1) / 2;
    localparam int ROOT_W = STEPS;
    localparam int PAD_W  = 2 * STEPS;
    localparam int RW     = ROOT_W + 3;

    logic              r_v    [STEPS];
    logic [PAD_W-1:0]  r_rad  [STEPS];
    logic [RW-1:0]     r_rem  [STEPS];
    logic [ROOT_W-1:0] r_root [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];

    // One result bit per stage: bring down two radicand bits, try the next root bit.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic              p_v;
        logic [PAD_W-1:0]  p_rad;
        logic [RW-1:0]     p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [SIDE_W-1:0] p_side;
        logic [RW-1:0]     rem_sh;
        logic [RW-1:0]     trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rad  = PAD_W'(i_rad);
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        assign rem_sh = {p_rem[RW-3:0], p_rad[2*(STEPS-1-k) +: 2]};
        assign trial  = RW'({p_root, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= p_rad;
            r_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
            r_root[k] <= {p_root[ROOT_W-2:0], ge};
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_root[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

// ===== rtl/core/rhb_div.sv =====
module rhb_div import rhb_pkg::*; #(
    parameter int DEN_W  = 19,
    parameter int Q_W    = 24,
    parameter int SIDE_W = 26
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [DEN_W+Q_W-1:0]   i_num,
    input  logic [DEN_W-1:0]       i_den,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_quo,
    output logic [SIDE_W-1:0]      o_side
);

    // The upper DEN_W bits of the numerator must already be below the divisor.
    logic              r_v    [Q_W];
    logic [DEN_W-1:0]  r_r    [Q_W];
    logic [Q_W-1:0]    r_nq   [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic              p_v;
        logic [DEN_W-1:0]  p_r;
        logic [Q_W-1:0]    p_nq;
        logic [SIDE_W-1:0] p_side;
        logic [DEN_W:0]    r_sh;
        logic [DEN_W:0]    r_sub;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_r    = i_num[DEN_W+Q_W-1:Q_W];
            assign p_nq   = i_num[Q_W-1:0];
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_r    = r_r[k-1];
            assign p_nq   = r_nq[k-1];
            assign p_side = r_side[k-1];
        end

        assign r_sh  = {p_r, p_nq[Q_W-1]};
        assign ge    = (r_sh >= {1'b0, i_den});
        assign r_sub = ge ? (r_sh - {1'b0, i_den}) : r_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_r[k]    <= r_sub[DEN_W-1:0];
            r_nq[k]   <= {p_nq[Q_W-2:0], ge};
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo   = r_nq[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

// ===== rtl/core/rhb_checker.sv =====
`include "radial_height_brush_unit_defines.svh"

module rhb_checker import rhb_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_cell   i_cell,
    input logic    busy,
    input logic    o_done,
    input t_result o_res
);

    localparam int LAT = rhb_latency(FRAC_BITS);

    `RHB_ASSERT_RST(a_item_gives_result, i_clk, i_rst_n, start && !busy |-> ##LAT o_done, "accepted item gave no result")
    `RHB_ASSERT_RST(a_result_has_item, i_clk, i_rst_n, o_done |-> $past(start && !busy, LAT), "result without an accepted item")
    `RHB_ASSERT_RST(a_untouched_passes, i_clk, i_rst_n, o_done && !o_res.touched |-> (o_res.new_height == $past(i_cell.cell_height, LAT)) && !o_res.clipped, "untouched cell changed")
    `RHB_ASSERT_ALL(a_clip_at_bound, i_clk, o_done && o_res.clipped |-> o_res.touched && (o_res.new_height == HMAX || o_res.new_height == HMIN), "clipped result off the bounds")

endmodule

bind radial_height_brush_unit rhb_checker #(.FRAC_BITS(FRAC_BITS)) u_rhb_checker (.*);

// ===== bench/tb_radial_height_brush_unit.sv =====
module tb_radial_height_brush_unit import rhb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Cell-to-result pipeline depth, plus margin for the drain at the end.
    localparam int PIPE_DEPTH = 50;
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 20;
    // No item is accepted and no result comes for this many cycles in a row: the run is hung.
    localparam int STALL_LIMIT = 2000;

    // Brush settings as the block should hold them, plus the expected heights.
    class brush_scoreboard;
        logic [9:0]         ctr_col;
        logic [9:0]         ctr_row;
        logic [18:0]        full_rad;
        logic [18:0]        ring_w;
        logic signed [23:0] lift;
        t_result            pending[$];
        int                 errors;

        function new();
            ctr_col = '0;
            ctr_row = '0;
            full_rad = '0;
            ring_w = '0;
            lift = '0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [23:0] val);
            case (idx)
                CFG_CENTER_X:      ctr_col = val[9:0];
                CFG_CENTER_Y:      ctr_row = val[9:0];
                CFG_RAISE_RADIUS:  full_rad = val[18:0];
                CFG_FEATHER_WIDTH: ring_w = val[18:0];
                CFG_LIFT_AMOUNT:   lift = val;
                default: ;
            endcase
        endfunction

        static function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Note one accepted cell: compute its brushed height and queue it.
        function void note_cell(t_cell c);
            longint unsigned dx, dy, dist2, reach, root_d, steps, mag, q;
            longint h, add;
            t_result r;
            h = c.cell_height;
            r.touched = 1'b0;
            r.clipped = 1'b0;
            dx = (c.cell_col >= ctr_col) ? c.cell_col - ctr_col : ctr_col - c.cell_col;
            dy = (c.cell_row >= ctr_row) ? c.cell_row - ctr_row : ctr_row - c.cell_row;
            dist2 = (dx * dx + dy * dy) << 16;
            reach = longint'(full_rad) + longint'(ring_w);
            if (dist2 <= reach * reach) begin
                r.touched = 1'b1;
                if (dist2 <= longint'(full_rad) * longint'(full_rad)) begin
                    add = lift;
                end else begin
                    root_d = root_floor(dist2);
                    steps = reach - root_d;
                    if (steps > ring_w) steps = ring_w;
                    mag = (lift < 0) ? -longint'(lift) : longint'(lift);
                    q = (mag * steps) / ring_w;
                    add = (lift < 0) ? -longint'(q) : longint'(q);
                end
                h = h + add;
                if (h > 8388607) begin
                    h = 8388607;
                    r.clipped = 1'b1;
                end
                if (h < -8388608) begin
                    h = -8388608;
                    r.clipped = 1'b1;
                end
            end
            r.new_height = h[23:0];
            pending = {pending, r};
        endfunction

        // Check one result strobe against the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("unexpected result: new_height=%0d", got.new_height);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.new_height !== want.new_height) begin
                $error("new_height: expected %0d, got %0d", want.new_height, got.new_height);
                errors++;
            end
            if (got.touched !== want.touched) begin
                $error("touched: expected %0b, got %0b", want.touched, got.touched);
                errors++;
            end
            if (got.clipped !== want.clipped) begin
                $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    t_cell                 i_cell = '0;
    logic                  busy;
    logic                  o_done;
    t_result               o_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    brush_scoreboard sb = new();
    int  idle_pct = 0;
    int  quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    radial_height_brush_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cell(i_cell),
        .busy(busy), .o_done(o_done), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Check results at the edge that ends their strobe cycle; count quiet cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_res);
        if (i_rst_n && ((start && !busy) || o_done)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Write one register; the block must be idle.
    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_brush(logic [9:0] cx, logic [9:0] cy, logic [18:0] rad,
                               logic [18:0] w, logic [23:0] amt);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RAISE_RADIUS, rad);
        write_reg(CFG_FEATHER_WIDTH, w);
        write_reg(CFG_LIFT_AMOUNT, amt);
    endtask

    // Offer one item; hold start until accepted, optionally idle first.
    task automatic send_cell(t_cell c);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cell <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_cell(c);
    endtask

    // Drop start, wait for all expected results and then the pipeline depth plus margin.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random cell, mostly near the center so the ring and disc get hit.
    function automatic t_cell rand_cell();
        t_cell c;
        int span;
        span = $urandom_range(3) == 0 ? 1023 : $urandom_range(40);
        c.cell_col = 10'(int'(sb.ctr_col) + $urandom_range(2 * span) - span);
        c.cell_row = 10'(int'(sb.ctr_row) + $urandom_range(2 * span) - span);
        case ($urandom_range(5))
            0: c.cell_height = 24'h7FFFFF - 24'($urandom_range(2000));
            1: c.cell_height = 24'h800000 + 24'($urandom_range(2000));
            default: c.cell_height = 24'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [18:0] rand_len();
        case ($urandom_range(4))
            0: return '0;
            1: return 19'h7FFFF;
            2: return 19'($urandom);
            default: return 19'($urandom_range(30 * 256));
        endcase
    endfunction

    function automatic logic [23:0] rand_lift();
        case ($urandom_range(4))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        t_cell c;
        int    phase;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings touch only the center cell.
        send_cell('{10'd0, 10'd0, 24'sd100});
        send_cell('{10'd1, 10'd0, 24'sd100});
        drain();
        // Disc, ring and outside with a full-scale lift; saturate at both ends.
        write_brush(10'd512, 10'd512, 19'd5 << 8, 19'd10 << 8, 24'h7FFFFF);
        send_cell('{10'd512, 10'd512, 24'h7FFFFF});
        send_cell('{10'd515, 10'd512, 24'sd0});
        send_cell('{10'd520, 10'd512, 24'h800000});
        send_cell('{10'd527, 10'd512, 24'sd0});
        send_cell('{10'd516, 10'd516, 24'sd7});
        send_cell('{10'd1023, 10'd1023, 24'sd5});
        send_cell('{10'd0, 10'd0, 24'h800000});
        drain();
        write_brush(10'd1023, 10'd0, 19'd3 << 8, 19'd0, 24'h800000);
        send_cell('{10'd1023, 10'd0, 24'h800000});
        send_cell('{10'd1020, 10'd0, 24'sd1});
        send_cell('{10'd1019, 10'd0, 24'sd1});
        send_cell('{10'd0, 10'd1023, 24'sd1});
        drain();
        write_brush(10'd0, 10'd1023, 19'h7FFFF, 19'h7FFFF, 24'h800000);
        send_cell('{10'd1023, 10'd0, 24'h7FFFFF});
        send_cell('{10'd0, 10'd1023, 24'h800001});
        drain();

        // Random phases, each with its own brush; the idle rate cycles with the phase.
        for (phase = 0; phase < 24; phase++) begin
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 63;
                2: idle_pct = 21;
                default: idle_pct = 0;
            endcase
            write_brush(10'($urandom), 10'($urandom), rand_len(), rand_len(), rand_lift());
            repeat (70) begin
                c = rand_cell();
                send_cell(c);
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rhb_pkg.sv
rtl/core/rhb_sqrt.sv
rtl/core/rhb_div.sv
rtl/core/radial_height_brush_unit.sv
rtl/core/rhb_checker.sv
bench/tb_radial_height_brush_unit.sv
